FILE: src/sdl_pkg.sv
package sdl_pkg;

  localparam int SLOT_W = 6;
  localparam int ADDR_W = SLOT_W + 1;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] SLIP_END = 8'hC0;
  localparam logic [7:0] SLIP_ESC = 8'hDB;
  localparam logic [7:0] ESC_END  = 8'hDC;
  localparam logic [7:0] ESC_ESC  = 8'hDD;
  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_LF   = 8'h0A;
  localparam logic [7:0] CHR_NUL  = 8'h00;
  localparam logic [7:0] CHR_SP   = 8'h20;
  localparam logic [7:0] CHR_TAB  = 8'h09;

  localparam logic KIND_LINE  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic       port;
    logic [7:0] rx_byte;
  } byte_item_t;

  typedef struct packed {
    logic       src_port;
    logic       kind;
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       last;
  } msg_item_t;

  // one delivery job: read entries lo_idx..hi_idx of the port's slot
  typedef struct packed {
    logic              port;
    logic              kind;
    logic              empty;
    logic [SLOT_W-1:0] lo_idx;
    logic [SLOT_W-1:0] hi_idx;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic valid;
    logic port;
  } done_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SHOW
  } back_state_t;

endpackage

FILE: src/sdl_store.sv
module sdl_store import sdl_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic              rd_en,
  input  logic              rd_kind,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] frame_mem [2**ADDR_W];
  logic [7:0] line_mem  [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr.en && wr.kind == KIND_FRAME) begin
      frame_mem[wr.addr] <= wr.data;
    end
    if (wr.en && wr.kind == KIND_LINE) begin
      line_mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= (rd_kind == KIND_FRAME) ? frame_mem[rd_addr] : line_mem[rd_addr];
    end
  end

endmodule

FILE: src/sdl_queue.sv
module sdl_queue import sdl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t       slots [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'(QUEUE_DEPTH));
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && head_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + 2'(push && !full) - 2'(pop && head_valid);
    end
  end

endmodule

FILE: src/sdl_front.sv
module sdl_front import sdl_pkg::*; #(
  parameter int FRAME_DEPTH = 64,
  parameter int LINE_DEPTH  = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_item,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd,
  output store_wr_t  wr,
  input  done_t      done
);

  logic [1:0]       in_frame, in_frame_next;
  logic [1:0]       esc, esc_next;
  logic [1:0]       cut, cut_next;
  logic [1:0]       has_nb, has_nb_next;
  logic [1:0]       busy, busy_next;
  logic [CNT_W-1:0] fcnt [2];
  logic [CNT_W-1:0] fcnt_next [2];
  logic [CNT_W-1:0] lcnt [2];
  logic [CNT_W-1:0] lcnt_next [2];
  logic [SLOT_W-1:0] first_nb [2];
  logic [SLOT_W-1:0] first_nb_next [2];
  logic [SLOT_W-1:0] last_nb [2];
  logic [SLOT_W-1:0] last_nb_next [2];

  logic       accept;
  logic       p;
  logic [7:0] b;
  logic       store_ok;
  logic [7:0] frame_data;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHR_SP) || (c >= CHR_TAB && c <= CHR_CR);
  endfunction

  assign p          = byte_item.port;
  assign b          = byte_item.rx_byte;
  // hold a port while its last message is still being delivered
  assign byte_stall = busy[p] || q_full;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    in_frame_next = in_frame;
    esc_next      = esc;
    cut_next      = cut;
    has_nb_next   = has_nb;
    fcnt_next     = fcnt;
    lcnt_next     = lcnt;
    first_nb_next = first_nb;
    last_nb_next  = last_nb;
    push          = 1'b0;
    push_cmd      = '0;
    wr            = '0;
    store_ok      = 1'b0;
    frame_data    = b;

    if (accept) begin
      if (in_frame[p]) begin
        if (b == SLIP_END) begin
          if (fcnt[p] != '0) begin
            push            = 1'b1;
            push_cmd.port   = p;
            push_cmd.kind   = KIND_FRAME;
            push_cmd.lo_idx = '0;
            push_cmd.hi_idx = SLOT_W'(fcnt[p] - CNT_W'(1));
          end
          in_frame_next[p] = 1'b0;
          esc_next[p]      = 1'b0;
          fcnt_next[p]     = '0;
        end else begin
          store_ok = 1'b1;
          if (esc[p]) begin
            esc_next[p] = 1'b0;
            if (b == ESC_END) begin
              frame_data = SLIP_END;
            end else if (b == ESC_ESC) begin
              frame_data = SLIP_ESC;
            end else begin
              store_ok         = 1'b0;
              in_frame_next[p] = 1'b0;
              fcnt_next[p]     = '0;
            end
          end else if (b == SLIP_ESC) begin
            esc_next[p] = 1'b1;
            store_ok    = 1'b0;
          end
          if (store_ok) begin
            if (fcnt[p] < CNT_W'(FRAME_DEPTH)) begin
              wr.en        = 1'b1;
              wr.kind      = KIND_FRAME;
              wr.addr      = {p, fcnt[p][SLOT_W-1:0]};
              wr.data      = frame_data;
              fcnt_next[p] = fcnt[p] + CNT_W'(1);
            end else begin
              in_frame_next[p] = 1'b0;
              esc_next[p]      = 1'b0;
              fcnt_next[p]     = '0;
            end
          end
        end
      end else if (b == SLIP_END) begin
        lcnt_next[p]     = '0;
        cut_next[p]      = 1'b0;
        has_nb_next[p]   = 1'b0;
        in_frame_next[p] = 1'b1;
        esc_next[p]      = 1'b0;
        fcnt_next[p]     = '0;
      end else if (b == CHR_LF) begin
        // trim bounds were tracked as the line came in
        push            = 1'b1;
        push_cmd.port   = p;
        push_cmd.kind   = KIND_LINE;
        push_cmd.empty  = !has_nb[p];
        push_cmd.lo_idx = first_nb[p];
        push_cmd.hi_idx = last_nb[p];
        lcnt_next[p]    = '0;
        cut_next[p]     = 1'b0;
        has_nb_next[p]  = 1'b0;
      end else if (b != CHR_CR) begin
        if (lcnt[p] < CNT_W'(LINE_DEPTH - 1)) begin
          wr.en        = 1'b1;
          wr.kind      = KIND_LINE;
          wr.addr      = {p, lcnt[p][SLOT_W-1:0]};
          wr.data      = b;
          lcnt_next[p] = lcnt[p] + CNT_W'(1);
          if (!cut[p]) begin
            if (b == CHR_NUL) begin
              cut_next[p] = 1'b1;
            end else if (!is_blank(b)) begin
              if (!has_nb[p]) begin
                first_nb_next[p] = lcnt[p][SLOT_W-1:0];
              end
              has_nb_next[p]  = 1'b1;
              last_nb_next[p] = lcnt[p][SLOT_W-1:0];
            end
          end
        end else begin
          lcnt_next[p]   = '0;
          cut_next[p]    = 1'b0;
          has_nb_next[p] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    busy_next = busy;
    if (done.valid) begin
      busy_next[done.port] = 1'b0;
    end
    if (push) begin
      busy_next[push_cmd.port] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= '0;
      esc      <= '0;
      cut      <= '0;
      has_nb   <= '0;
      busy     <= '0;
      fcnt     <= '{default: '0};
      lcnt     <= '{default: '0};
      first_nb <= '{default: '0};
      last_nb  <= '{default: '0};
    end else begin
      in_frame <= in_frame_next;
      esc      <= esc_next;
      cut      <= cut_next;
      has_nb   <= has_nb_next;
      busy     <= busy_next;
      fcnt     <= fcnt_next;
      lcnt     <= lcnt_next;
      first_nb <= first_nb_next;
      last_nb  <= last_nb_next;
    end
  end

`ifndef SYNTHESIS
  a_wr_idle_port: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !busy[wr.addr[ADDR_W-1]])
    else $error("store written for a port still delivering");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full && !busy[push_cmd.port])
    else $error("job pushed without room");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done.valid |-> busy[done.port])
    else $error("delivery finished for a port with no job");
`endif

endmodule

FILE: src/sdl_back.sv
module sdl_back import sdl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  cmd_t              head_cmd,
  output logic              pop,
  output logic              rd_en,
  output logic              rd_kind,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              msg_valid,
  input  logic              msg_stall,
  output msg_item_t         msg_item,
  output done_t             done
);

  back_state_t       state, state_next;
  cmd_t              job, job_next;
  logic [SLOT_W-1:0] idx, idx_next;
  logic              at_end;

  assign at_end = job.empty || (idx == job.hi_idx);

  always_comb begin
    state_next = state;
    job_next   = job;
    idx_next   = idx;
    pop        = 1'b0;
    rd_en      = 1'b0;
    rd_kind    = job.kind;
    rd_addr    = {job.port, idx};
    msg_valid  = 1'b0;
    done       = '0;
    case (state)
      B_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          job_next   = head_cmd;
          idx_next   = head_cmd.lo_idx;
          state_next = head_cmd.empty ? B_SHOW : B_READ;
        end
      end
      B_READ: begin
        rd_en      = 1'b1;
        state_next = B_SHOW;
      end
      B_SHOW: begin
        msg_valid = 1'b1;
        if (!msg_stall) begin
          if (at_end) begin
            done.valid = 1'b1;
            done.port  = job.port;
            state_next = B_IDLE;
          end else begin
            idx_next   = idx + SLOT_W'(1);
            state_next = B_READ;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    msg_item.src_port = job.port;
    msg_item.kind     = job.kind;
    msg_item.msg_byte = job.empty ? 8'h00 : rd_data;
    msg_item.has_byte = !job.empty;
    msg_item.last     = at_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    job <= job_next;
    idx <= idx_next;
  end

endmodule

FILE: src/slip_and_line_deframer.sv
// Channel  Direction  Payload       Handshake
// byte     in         byte_item_t   byte_valid / byte_stall
// msg      out        msg_item_t    msg_valid / msg_stall
//
// Each delivered message byte passes through a store read (B_READ) and an output
// state (B_SHOW) in the back end; a byte that delivers nothing is absorbed on acceptance.
// The back end picks up each message from the queue in B_IDLE; the first result passes through the queue,
// the pickup and the store read before it can transfer; an empty line skips the read.
// While a port has a message in delivery, further bytes on that port are stalled;
// bytes of the other port keep flowing.
// rst is synchronous and clears all port context; the stores need no clearing.
module slip_and_line_deframer import sdl_pkg::*; #(
  parameter int FRAME_DEPTH = 64,
  parameter int LINE_DEPTH  = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_item,
  output logic       msg_valid,
  input  logic       msg_stall,
  output msg_item_t  msg_item
);

  logic              q_full;
  logic              push;
  cmd_t              push_cmd;
  logic              pop;
  logic              head_valid;
  cmd_t              head_cmd;
  store_wr_t         wr;
  done_t             done;
  logic              rd_en;
  logic              rd_kind;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  sdl_front #(
    .FRAME_DEPTH(FRAME_DEPTH),
    .LINE_DEPTH (LINE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .wr        (wr),
    .done      (done)
  );

  sdl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  sdl_store u_store (
    .clk    (clk),
    .wr     (wr),
    .rd_en  (rd_en),
    .rd_kind(rd_kind),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sdl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .rd_en     (rd_en),
    .rd_kind   (rd_kind),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg_item  (msg_item),
    .done      (done)
  );

endmodule
